@@ hw/rtl/qwi_pkg.sv @@
package qwi_pkg;

  // Table geometry
  localparam int MAX_POINTS = 16;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);

  // Datapath widths
  localparam int POS_W      = 96;   // three Q16.16 axes per table row
  localparam int U_W        = 31;   // tau in Q1.30, up to and including 1.0
  localparam int S_W        = 34;   // smoothstep terms and multiplier operands
  localparam int POLY_W     = 40;   // width of the polynomial sums before trimming
  localparam int DVD_W      = 63;   // divider dividend and quotient
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int QBITS      = 30;
  localparam int VEL_SHIFT  = 14;
  localparam int ACC_SHIFT  = 12;

  // Request commands
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_LOOP  = 2'd2,
    CMD_CLEAR = 2'd3
  } qwi_cmd_code_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INTERP   = 3'd0,
    ST_BEFORE   = 3'd1,
    ST_AFTER    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_LOAD_OK  = 3'd4,
    ST_LOAD_REJ = 3'd5
  } qwi_status_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP    = 5'd0,
    OP_CLEAR  = 5'd1,
    OP_APPEND = 5'd2,
    OP_TSCAN  = 5'd3,
    OP_P0     = 5'd4,
    OP_D      = 5'd5,
    OP_DIV_U  = 5'd6,
    OP_U      = 5'd7,
    OP_PW     = 5'd8,
    OP_POLY   = 5'd9,
    OP_MUL_S0 = 5'd10,
    OP_MUL_S1 = 5'd11,
    OP_MUL_S2 = 5'd12,
    OP_POS    = 5'd13,
    OP_DIV_P  = 5'd14,
    OP_DIV_Q  = 5'd15,
    OP_VEL    = 5'd16,
    OP_ACC    = 5'd17,
    OP_HOLD   = 5'd18
  } qwi_op_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        time_req;
    logic signed [31:0] point_0;
    logic signed [31:0] point_1;
    logic signed [31:0] point_2;
  } qwi_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] pos_0;
    logic signed [31:0] pos_1;
    logic signed [31:0] pos_2;
    logic signed [63:0] vel_0;
    logic signed [63:0] vel_1;
    logic signed [63:0] vel_2;
    logic signed [63:0] acc_0;
    logic signed [63:0] acc_1;
    logic signed [63:0] acc_2;
  } qwi_out_t;

  // Controller to datapath
  typedef struct packed {
    logic              cap;
    logic              emit;
    qwi_status_t       status;
    logic              t_re;
    logic              p_re;
    logic              we;
    logic              wr_first;
    logic [ADDR_W-1:0] addr;
    qwi_op_t           op;
    logic [1:0]        sel;
  } qwi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0]       command;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             t_le_last;
    logic             t_lt_t1;
    logic             t_le_t1;
    logic             div_busy;
    logic             out_free;
  } qwi_stat_t;

endpackage

@@ hw/rtl/qwi_ram.sv @@
module qwi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/qwi_div.sv @@
module qwi_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [qwi_pkg::DVD_W-1:0] dividend,
  input  logic [31:0]               divisor,
  output logic                      busy,
  output logic [qwi_pkg::DVD_W-1:0] quotient
);
  import qwi_pkg::*;

  logic [DVD_W-1:0]     q_r;
  logic [31:0]          rem_r;
  logic [31:0]          dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [32:0]          rem_sh;
  logic [32:0]          diff;
  logic                 ge;

  // restoring step: one quotient bit per cycle
  assign rem_sh = {rem_r, q_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DVD_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      q_r   <= {q_r[DVD_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

@@ hw/rtl/qwi_datapath.sv @@
module qwi_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  qwi_pkg::qwi_in_t   in_data,
  input  qwi_pkg::qwi_cmd_t  cmd,
  output qwi_pkg::qwi_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output qwi_pkg::qwi_out_t  out_data
);
  import qwi_pkg::*;

  qwi_in_t                   req_r;
  qwi_out_t                  out_r;
  logic                      out_valid_r;
  logic [CNT_W-1:0]          count_r;
  logic [31:0]               last_time_r;
  logic [31:0]               t_rd;
  logic [POS_W-1:0]          p_rd;
  logic [POS_W-1:0]          p_wdata;
  logic [31:0]               t0_r;
  logic [31:0]               t1_r;
  logic [31:0]               dt;
  logic [31:0]               t_ofs;
  logic signed [31:0]        p0_r [3];
  logic signed [32:0]        d_r [3];
  logic [U_W-1:0]            u_r;
  logic [U_W-1:0]            pw_r [4];
  logic [U_W-1:0]            pw_a;
  logic signed [S_W-1:0]     s0_r;
  logic signed [S_W-1:0]     s1_r;
  logic signed [S_W-1:0]     s2q_r;
  logic signed [POLY_W-1:0]  e1;
  logic signed [POLY_W-1:0]  e2;
  logic signed [POLY_W-1:0]  e3;
  logic signed [POLY_W-1:0]  e4;
  logic signed [POLY_W-1:0]  e5;
  logic signed [POLY_W-1:0]  s0_w;
  logic signed [POLY_W-1:0]  s1_w;
  logic signed [POLY_W-1:0]  s2_w;
  logic signed [S_W-1:0]     ma;
  logic signed [S_W-1:0]     mb;
  logic signed [2*S_W-1:0]   mprod;
  logic signed [63:0]        prod_r;
  logic [63:0]               prod_neg;
  logic [DVD_W-1:0]          prod_mag;
  logic                      neg_r;
  logic signed [34:0]        pos_sum;
  logic signed [31:0]        pos_sat;
  logic signed [31:0]        pos_r [3];
  logic signed [63:0]        vel_r [3];
  logic signed [63:0]        acc_r [3];
  logic [63:0]               vel_mag;
  logic [63:0]               acc_mag;
  logic                      div_start;
  logic                      div_busy;
  logic [DVD_W-1:0]          div_dvd;
  logic [DVD_W-1:0]          div_q;

  // waypoint tables
  assign p_wdata = cmd.wr_first ? p_rd : {req_r.point_2, req_r.point_1, req_r.point_0};

  qwi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_time_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.addr),
    .wdata (req_r.time_req),
    .re    (cmd.t_re),
    .raddr (cmd.addr),
    .rdata (t_rd)
  );

  qwi_ram #(.WIDTH(POS_W), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.addr),
    .wdata (p_wdata),
    .re    (cmd.p_re),
    .raddr (cmd.addr),
    .rdata (p_rd)
  );

  // segment timing
  assign dt    = t1_r - t0_r;
  assign t_ofs = req_r.time_req - t0_r;

  // shared divider: tau, then velocity and acceleration magnitudes
  assign div_start = (cmd.op == OP_DIV_U) || (cmd.op == OP_DIV_P) || (cmd.op == OP_DIV_Q);
  assign prod_neg  = -prod_r;
  assign prod_mag  = prod_r[63] ? prod_neg[DVD_W-1:0] : prod_r[DVD_W-1:0];

  always_comb begin
    case (cmd.op)
      OP_DIV_U: div_dvd = {1'b0, t_ofs, {QBITS{1'b0}}};
      OP_DIV_P: div_dvd = prod_mag;
      default:  div_dvd = div_q;
    endcase
  end

  qwi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // shared multiplier operand select
  assign pw_a = (cmd.sel == 2'd0) ? u_r : pw_r[cmd.sel - 2'd1];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_PW: begin
        ma = $signed({{(S_W-U_W){1'b0}}, pw_a});
        mb = $signed({{(S_W-U_W){1'b0}}, u_r});
      end
      OP_MUL_S0: begin
        ma = s0_r;
        mb = $signed({{(S_W-33){d_r[cmd.sel][32]}}, d_r[cmd.sel]});
      end
      OP_MUL_S1: begin
        ma = s1_r;
        mb = $signed({{(S_W-33){d_r[cmd.sel][32]}}, d_r[cmd.sel]});
      end
      OP_MUL_S2: begin
        ma = s2q_r;
        mb = $signed({{(S_W-33){d_r[cmd.sel][32]}}, d_r[cmd.sel]});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mprod = ma * mb;

  // smoothstep and its derivatives, Q30
  assign e1 = $signed({{(POLY_W-U_W){1'b0}}, u_r});
  assign e2 = $signed({{(POLY_W-U_W){1'b0}}, pw_r[0]});
  assign e3 = $signed({{(POLY_W-U_W){1'b0}}, pw_r[1]});
  assign e4 = $signed({{(POLY_W-U_W){1'b0}}, pw_r[2]});
  assign e5 = $signed({{(POLY_W-U_W){1'b0}}, pw_r[3]});

  assign s0_w = 40'sd10 * e3 - 40'sd15 * e4 + 40'sd6 * e5;
  assign s1_w = 40'sd30 * e2 - 40'sd60 * e3 + 40'sd30 * e4;
  assign s2_w = 40'sd60 * e1 - 40'sd180 * e2 + 40'sd120 * e3;

  // position: start point plus floored product, saturated to 32 bits
  assign pos_sum = $signed({{3{p0_r[cmd.sel][31]}}, p0_r[cmd.sel]})
                 + $signed({prod_r[63], prod_r[63:QBITS]});

  always_comb begin
    if ((pos_sum[34:31] == 4'b0000) || (pos_sum[34:31] == 4'b1111)) begin
      pos_sat = pos_sum[31:0];
    end else if (pos_sum[34]) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = 32'sh7fff_ffff;
    end
  end

  // truncating scale of the divider quotient, sign restored
  assign vel_mag = {1'b0, div_q >> VEL_SHIFT};
  assign acc_mag = {1'b0, div_q >> ACC_SHIFT};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        count_r <= '0;
      end else if (cmd.op == OP_APPEND) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_data;
      for (int k = 0; k < 3; k++) begin
        pos_r[k] <= '0;
        vel_r[k] <= '0;
        acc_r[k] <= '0;
      end
    end
    case (cmd.op)
      OP_APPEND: last_time_r <= req_r.time_req;
      OP_TSCAN: begin
        t0_r <= t1_r;
        t1_r <= t_rd;
      end
      OP_P0: begin
        for (int k = 0; k < 3; k++) begin
          p0_r[k] <= p_rd[32*k +: 32];
        end
      end
      OP_D: begin
        for (int k = 0; k < 3; k++) begin
          d_r[k] <= $signed({p_rd[32*k+31], p_rd[32*k +: 32]})
                  - $signed({p0_r[k][31], p0_r[k]});
        end
      end
      OP_U:      u_r <= div_q[U_W-1:0];
      OP_PW:     pw_r[cmd.sel] <= mprod[QBITS+U_W-1:QBITS];
      OP_POLY: begin
        s0_r  <= s0_w[S_W-1:0];
        s1_r  <= s1_w[S_W-1:0];
        s2q_r <= s2_w[S_W+1:2];
      end
      OP_MUL_S0, OP_MUL_S1, OP_MUL_S2: prod_r <= mprod[63:0];
      OP_POS:    pos_r[cmd.sel] <= pos_sat;
      OP_DIV_P:  neg_r <= prod_r[63];
      OP_VEL:    vel_r[cmd.sel] <= neg_r ? -$signed(vel_mag) : $signed(vel_mag);
      OP_ACC:    acc_r[cmd.sel] <= neg_r ? -$signed(acc_mag) : $signed(acc_mag);
      OP_HOLD: begin
        for (int k = 0; k < 3; k++) begin
          pos_r[k] <= p_rd[32*k +: 32];
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status <= cmd.status;
      out_r.pos_0  <= pos_r[0];
      out_r.pos_1  <= pos_r[1];
      out_r.pos_2  <= pos_r[2];
      out_r.vel_0  <= vel_r[0];
      out_r.vel_1  <= vel_r[1];
      out_r.vel_2  <= vel_r[2];
      out_r.acc_0  <= acc_r[0];
      out_r.acc_1  <= acc_r[1];
      out_r.acc_2  <= acc_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status back to the controller
  assign stat.command   = req_r.command;
  assign stat.count     = count_r;
  assign stat.full      = (count_r == CNT_W'(MAX_POINTS));
  assign stat.t_le_last = (req_r.time_req <= last_time_r);
  assign stat.t_lt_t1   = (req_r.time_req < t1_r);
  assign stat.t_le_t1   = (req_r.time_req <= t1_r);
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid_r || out_ready;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("waypoint count beyond table size");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_tau_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_U) |=> (u_r <= (U_W'(1) << (U_W - 1))))
    else $error("tau above one");

endmodule

@@ hw/rtl/qwi_ctrl.sv @@
module qwi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qwi_pkg::qwi_stat_t stat,
  output qwi_pkg::qwi_cmd_t  cmd
);
  import qwi_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_DEC   = 24'h000002,
    S_LOOPW = 24'h000004,
    S_FIRST = 24'h000008,
    S_CHK   = 24'h000010,
    S_SCAN  = 24'h000020,
    S_SCHK  = 24'h000040,
    S_P0    = 24'h000080,
    S_PD    = 24'h000100,
    S_DIVU  = 24'h000200,
    S_WU    = 24'h000400,
    S_PW    = 24'h000800,
    S_POLY  = 24'h001000,
    S_MS0   = 24'h002000,
    S_POS   = 24'h004000,
    S_MS1   = 24'h008000,
    S_DV    = 24'h010000,
    S_WV    = 24'h020000,
    S_MS2   = 24'h040000,
    S_DA    = 24'h080000,
    S_WA1   = 24'h100000,
    S_WA2   = 24'h200000,
    S_HOLD  = 24'h400000,
    S_EMIT  = 24'h800000
  } qwi_state_t;

  qwi_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [1:0]        k_r, k_nxt;
  qwi_status_t       status_r, status_nxt;
  logic [CNT_W-1:0]  last_cnt;
  logic [ADDR_W-1:0] last_idx;
  logic              reject;

  assign last_cnt = stat.count - CNT_W'(1);
  assign last_idx = last_cnt[ADDR_W-1:0];
  assign reject   = stat.full || ((stat.count != '0) && stat.t_le_last);
  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    status_nxt   = status_r;
    cmd          = '0;
    cmd.op       = OP_NOP;
    cmd.status   = status_r;
    cmd.sel      = k_r;
    cmd.addr     = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.command)
          CMD_ADD: begin
            if (reject) begin
              status_nxt = ST_LOAD_REJ;
            end else begin
              cmd.we     = 1'b1;
              cmd.addr   = stat.count[ADDR_W-1:0];
              cmd.op     = OP_APPEND;
              status_nxt = ST_LOAD_OK;
            end
            state_nxt = S_EMIT;
          end
          CMD_LOOP: begin
            if ((stat.count == '0) || reject) begin
              status_nxt = ST_LOAD_REJ;
              state_nxt  = S_EMIT;
            end else begin
              cmd.p_re  = 1'b1;
              cmd.addr  = '0;
              state_nxt = S_LOOPW;
            end
          end
          CMD_CLEAR: begin
            cmd.op     = OP_CLEAR;
            status_nxt = ST_LOAD_OK;
            state_nxt  = S_EMIT;
          end
          CMD_QUERY: begin
            if (stat.count == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_EMIT;
            end else begin
              cmd.t_re  = 1'b1;
              cmd.addr  = '0;
              state_nxt = S_FIRST;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LOOPW: begin
        cmd.we       = 1'b1;
        cmd.wr_first = 1'b1;
        cmd.addr     = stat.count[ADDR_W-1:0];
        cmd.op       = OP_APPEND;
        status_nxt   = ST_LOAD_OK;
        state_nxt    = S_EMIT;
      end
      S_FIRST: begin
        cmd.op    = OP_TSCAN;
        state_nxt = S_CHK;
      end
      // before start, after end, single point, or walk the segments
      S_CHK: begin
        if (stat.t_lt_t1) begin
          cmd.p_re   = 1'b1;
          cmd.addr   = '0;
          status_nxt = ST_BEFORE;
          state_nxt  = S_HOLD;
        end else if (!stat.t_le_last) begin
          cmd.p_re   = 1'b1;
          cmd.addr   = last_idx;
          status_nxt = ST_AFTER;
          state_nxt  = S_HOLD;
        end else if (stat.count == CNT_W'(1)) begin
          cmd.p_re   = 1'b1;
          cmd.addr   = '0;
          status_nxt = ST_INTERP;
          state_nxt  = S_HOLD;
        end else begin
          cmd.t_re  = 1'b1;
          cmd.addr  = ADDR_W'(1);
          idx_nxt   = ADDR_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op    = OP_TSCAN;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (stat.t_le_t1 || (idx_r == last_idx)) begin
          cmd.p_re  = 1'b1;
          cmd.addr  = idx_r - ADDR_W'(1);
          state_nxt = S_P0;
        end else begin
          cmd.t_re  = 1'b1;
          cmd.addr  = idx_r + ADDR_W'(1);
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_P0: begin
        cmd.op    = OP_P0;
        cmd.p_re  = 1'b1;
        cmd.addr  = idx_r;
        state_nxt = S_PD;
      end
      S_PD: begin
        cmd.op    = OP_D;
        state_nxt = S_DIVU;
      end
      S_DIVU: begin
        cmd.op    = OP_DIV_U;
        state_nxt = S_WU;
      end
      S_WU: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_U;
          k_nxt     = 2'd0;
          state_nxt = S_PW;
        end
      end
      // powers of tau, one multiply each
      S_PW: begin
        cmd.op = OP_PW;
        if (k_r == 2'd3) begin
          k_nxt     = 2'd0;
          state_nxt = S_POLY;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_POLY: begin
        cmd.op    = OP_POLY;
        k_nxt     = 2'd0;
        state_nxt = S_MS0;
      end
      // per axis: position, velocity, acceleration
      S_MS0: begin
        cmd.op    = OP_MUL_S0;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd.op    = OP_POS;
        state_nxt = S_MS1;
      end
      S_MS1: begin
        cmd.op    = OP_MUL_S1;
        state_nxt = S_DV;
      end
      S_DV: begin
        cmd.op    = OP_DIV_P;
        state_nxt = S_WV;
      end
      S_WV: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_VEL;
          state_nxt = S_MS2;
        end
      end
      S_MS2: begin
        cmd.op    = OP_MUL_S2;
        state_nxt = S_DA;
      end
      S_DA: begin
        cmd.op    = OP_DIV_P;
        state_nxt = S_WA1;
      end
      S_WA1: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_DIV_Q;
          state_nxt = S_WA2;
        end
      end
      S_WA2: begin
        if (!stat.div_busy) begin
          cmd.op = OP_ACC;
          if (k_r == 2'd2) begin
            status_nxt = ST_INTERP;
            state_nxt  = S_EMIT;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_MS0;
          end
        end
      end
      S_HOLD: begin
        cmd.op    = OP_HOLD;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      k_r      <= '0;
      status_r <= ST_INTERP;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      k_r      <= k_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

@@ hw/rtl/quintic_waypoint_interpolator_core.sv @@
// Channel | Direction | Ports                            | Moves
// in      | input     | in_valid, in_ready, in_data      | one request
// out     | output    | out_valid, out_ready, out_data   | one result per request
//
// One request at a time. An interpolated query scans the table for its segment
// and runs ten divisions (tau, three velocities, six for acceleration) in one
// bit-serial divider. Reset (rst_n low, synchronous) empties the table; a result
// waiting in the output register does not stop the next request from being taken,
// but that request's result waits until the register is free.

module quintic_waypoint_interpolator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qwi_pkg::qwi_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qwi_pkg::qwi_out_t out_data
);
  import qwi_pkg::*;

  qwi_cmd_t  cmd;
  qwi_stat_t stat;

  qwi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qwi_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/quintic_waypoint_interpolator_core_tb.sv @@
`timescale 1ns / 100ps

module quintic_waypoint_interpolator_core_tb;
  import qwi_pkg::*;

  localparam int N_ITEMS   = 800;
  localparam int DRAIN_CYC = 1000;
  localparam int HOLD_CYC  = 3000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  qwi_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  qwi_out_t out_data;

  always #5 clk = ~clk;

  quintic_waypoint_interpolator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the waypoint table
  logic [31:0]        wp_time [MAX_POINTS];
  logic signed [31:0] wp_pos  [MAX_POINTS][3];
  int                 wp_count;

  qwi_out_t pending_results[$];
  int       n_sent;
  int       n_errors;
  int       burst_left;
  bit       hold_off_req;

  // Expected result of one request; updates the shadow table
  function automatic qwi_out_t interp_result(qwi_in_t r);
    qwi_out_t           o;
    logic signed [31:0] p [3];
    longint             pos [3], vel [3], acc [3];
    longint unsigned    dt, u, p1, p2, p3, p4, p5;
    longint             s0, s1, s2, s2q, vden, aden, a, d, x;
    int                 last, seg, idx;
    logic [31:0]        t, t0;
    o = '0;
    t = r.time_req;
    p[0] = r.point_0; p[1] = r.point_1; p[2] = r.point_2;
    for (int k = 0; k < 3; k++) begin
      pos[k] = 0; vel[k] = 0; acc[k] = 0;
    end
    case (r.command)
      CMD_ADD, CMD_LOOP: begin
        if (r.command == CMD_LOOP && wp_count == 0) begin
          o.status = ST_LOAD_REJ;
        end else if (wp_count >= MAX_POINTS ||
                     (wp_count > 0 && t <= wp_time[wp_count-1])) begin
          o.status = ST_LOAD_REJ;
        end else begin
          wp_time[wp_count] = t;
          for (int k = 0; k < 3; k++)
            wp_pos[wp_count][k] = (r.command == CMD_LOOP) ? wp_pos[0][k] : p[k];
          wp_count++;
          o.status = ST_LOAD_OK;
        end
      end
      CMD_CLEAR: begin
        wp_count = 0;
        o.status = ST_LOAD_OK;
      end
      default: begin
        last = wp_count - 1;
        if (wp_count == 0) begin
          o.status = ST_EMPTY;
        end else if (t < wp_time[0] || t > wp_time[last] || last == 0) begin
          // hold an end point, no motion
          o.status = (t < wp_time[0]) ? ST_BEFORE : (t > wp_time[last]) ? ST_AFTER
                                                                           : ST_INTERP;
          idx = (t < wp_time[0]) ? 0 : last;
          for (int k = 0; k < 3; k++) pos[k] = wp_pos[idx][k];
        end else begin
          seg = 0;
          while (seg + 1 < last && t > wp_time[seg+1]) seg++;
          o.status = ST_INTERP;
          t0 = wp_time[seg];
          dt = longint'(wp_time[seg+1] - t0);
          u  = (longint'(t - t0) << QBITS) / dt;
          p1 = u;
          p2 = (p1 * u) >> QBITS;
          p3 = (p2 * u) >> QBITS;
          p4 = (p3 * u) >> QBITS;
          p5 = (p4 * u) >> QBITS;
          s0 = 10 * longint'(p3) - 15 * longint'(p4) + 6 * longint'(p5);
          s1 = 30 * longint'(p2) - 60 * longint'(p3) + 30 * longint'(p4);
          s2 = 60 * longint'(p1) - 180 * longint'(p2) + 120 * longint'(p3);
          s2q = s2 >>> 2;
          vden = longint'(dt << VEL_SHIFT);
          aden = longint'(dt << ACC_SHIFT);
          for (int k = 0; k < 3; k++) begin
            a = wp_pos[seg][k];
            d = longint'(wp_pos[seg+1][k]) - a;
            x = a + ((s0 * d) >>> QBITS);
            if (x > 64'sd2147483647) x = 64'sd2147483647;
            if (x < -64'sd2147483648) x = -64'sd2147483648;
            pos[k] = x;
            vel[k] = (s1 * d) / vden;
            acc[k] = ((s2q * d) / aden) / longint'(dt);
          end
        end
      end
    endcase
    o.pos_0 = pos[0][31:0]; o.pos_1 = pos[1][31:0]; o.pos_2 = pos[2][31:0];
    o.vel_0 = vel[0]; o.vel_1 = vel[1]; o.vel_2 = vel[2];
    o.acc_0 = acc[0]; o.acc_1 = acc[1]; o.acc_2 = acc[2];
    return o;
  endfunction

  function automatic qwi_in_t mk_req(qwi_cmd_code_t c, logic [31:0] t,
                                     logic [31:0] a, logic [31:0] b, logic [31:0] e);
    qwi_in_t r;
    r.command = c; r.time_req = t; r.point_0 = a; r.point_1 = b; r.point_2 = e;
    return r;
  endfunction

  // Offer one request and hold it until taken; typed_want overrides the prediction
  task automatic send_req(qwi_in_t r, bit typed, qwi_out_t typed_want);
    qwi_out_t e;
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    e = interp_result(r);
    pending_results.push_back(typed ? typed_want : e);
    n_sent++;
    if (burst_left == 0) begin
      in_valid   <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send(qwi_in_t r);
    send_req(r, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_point();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // Directed table
  typedef struct {
    qwi_in_t  req;
    bit       typed;
    qwi_out_t want;
  } dir_row_t;

  function automatic dir_row_t mk_row(qwi_cmd_code_t c, logic [31:0] t, logic [31:0] a,
                                      logic [31:0] b, logic [31:0] e, bit typed,
                                      qwi_status_t st, logic [31:0] q0, logic [31:0] q1,
                                      logic [31:0] q2);
    dir_row_t row;
    row.req   = mk_req(c, t, a, b, e);
    row.typed = typed;
    row.want  = '0;
    row.want.status = st;
    row.want.pos_0 = q0; row.want.pos_1 = q1; row.want.pos_2 = q2;
    return row;
  endfunction

  // Result checking
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $realtime);
    end
  endtask

  always @(posedge clk) begin
    qwi_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p at %0t", out_data, $realtime);
      end else begin
        e = pending_results.pop_front();
        check_field("status", 64'(e.status), 64'(out_data.status));
        check_field("pos_0", 64'(e.pos_0), 64'(out_data.pos_0));
        check_field("pos_1", 64'(e.pos_1), 64'(out_data.pos_1));
        check_field("pos_2", 64'(e.pos_2), 64'(out_data.pos_2));
        check_field("vel_0", e.vel_0, out_data.vel_0);
        check_field("vel_1", e.vel_1, out_data.vel_1);
        check_field("vel_2", e.vel_2, out_data.vel_2);
        check_field("acc_0", e.acc_0, out_data.acc_0);
        check_field("acc_1", e.acc_1, out_data.acc_1);
        check_field("acc_2", e.acc_2, out_data.acc_2);
      end
    end
  end

  // Result side stall pattern, with long hold-offs on request
  initial begin
    int mode;
    int span;
    int hold_cnt;
    mode = 0;
    span = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && hold_cnt == 0) begin
        hold_cnt = HOLD_CYC;
        hold_off_req = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(8, 80);
      end
      span--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus
  initial begin
    dir_row_t    rows[$];
    int          n_pts, n_q, idx, drain_cnt;
    logic [31:0] t, base;
    n_sent = 0;
    n_errors = 0;
    burst_left = 0;
    hold_off_req = 1'b0;
    wp_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
    rows.push_back(mk_row(CMD_LOOP, 10, 0, 0, 0, 1, ST_LOAD_REJ, 0, 0, 0));
    rows.push_back(mk_row(CMD_ADD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1,
                          ST_LOAD_OK, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 0, 1, ST_INTERP,
                          32'h7FFF_FFFF, 32'h8000_0000, 0));
    rows.push_back(mk_row(CMD_QUERY, 5, 0, 0, 0, 1, ST_AFTER,
                          32'h7FFF_FFFF, 32'h8000_0000, 0));
    rows.push_back(mk_row(CMD_ADD, 0, 1, 2, 3, 1, ST_LOAD_REJ, 0, 0, 0));
    rows.push_back(mk_row(CMD_ADD, 1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
                          ST_LOAD_OK, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 0, 1, ST_INTERP,
                          32'h7FFF_FFFF, 32'h8000_0000, 0));
    rows.push_back(mk_row(CMD_QUERY, 1000, 0, 0, 0, 1, ST_INTERP,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    rows.push_back(mk_row(CMD_QUERY, 500, 0, 0, 0, 0, ST_INTERP, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 1, 0, 0, 0, 0, ST_INTERP, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 999, 0, 0, 0, 0, ST_INTERP, 0, 0, 0));
    rows.push_back(mk_row(CMD_LOOP, 1000, 0, 0, 0, 1, ST_LOAD_REJ, 0, 0, 0));
    rows.push_back(mk_row(CMD_LOOP, 2000, 5, 6, 7, 1, ST_LOAD_OK, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 1500, 0, 0, 0, 0, ST_INTERP, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 1001, 0, 0, 0, 0, ST_INTERP, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 1, ST_AFTER,
                          32'h7FFF_FFFF, 32'h8000_0000, 0));
    rows.push_back(mk_row(CMD_CLEAR, 0, 0, 0, 0, 1, ST_LOAD_OK, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 7, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
    rows.push_back(mk_row(CMD_ADD, 32'hFFFF_FFFE, 32'hFFFF_0000, 32'h0001_0000, 32'h1234_5678,
                          1, ST_LOAD_OK, 0, 0, 0));
    rows.push_back(mk_row(CMD_ADD, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'hEDCB_A988,
                          1, ST_LOAD_OK, 0, 0, 0));
    rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 0, 1, ST_BEFORE,
                          32'hFFFF_0000, 32'h0001_0000, 32'h1234_5678));
    rows.push_back(mk_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 1, ST_INTERP,
                          32'h0001_0000, 32'hFFFF_0000, 32'hEDCB_A988));
    rows.push_back(mk_row(CMD_CLEAR, 0, 0, 0, 0, 1, ST_LOAD_OK, 0, 0, 0));
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].want);

    // Random part: build tables, then query them, with some noise mixed in
    while (n_sent < N_ITEMS) begin
      if (n_sent > 300 && n_sent < 330) hold_off_req = 1'b1;
      if (n_sent > 500 && n_sent < 520) drain_results();
      if ($urandom_range(0, 9) == 0) begin
        send(mk_req(qwi_cmd_code_t'($urandom_range(0, 3)), $urandom(), $urandom(),
                    $urandom(), $urandom()));
        continue;
      end
      if ($urandom_range(0, 4) != 0) send(mk_req(CMD_CLEAR, $urandom(), 0, 0, 0));
      n_pts = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
      base  = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4000);
      t     = base;
      for (int k = 0; k < n_pts; k++) begin
        if (k == n_pts - 1 && $urandom_range(0, 2) == 0) begin
          send(mk_req(CMD_LOOP, t, $urandom(), $urandom(), $urandom()));
        end else begin
          send(mk_req(($urandom_range(0, 15) == 0) ? CMD_LOOP : CMD_ADD, t,
                      rand_point(), rand_point(), rand_point()));
        end
        case ($urandom_range(0, 9))
          0:       t = t;
          1, 2:    t = t + $urandom_range(1, 3);
          3:       t = t + $urandom_range(1, 32'h0100_0000);
          default: t = t + $urandom_range(1, 300);
        endcase
        if (t < base) t = 32'hFFFF_FFFF;
      end
      n_q = $urandom_range(2, 8);
      for (int k = 0; k < n_q; k++) begin
        idx = $urandom_range(0, (wp_count > 0) ? wp_count - 1 : 0);
        case ($urandom_range(0, 5))
          0:       t = $urandom();
          1:       t = wp_time[idx];
          2:       t = wp_time[idx] + $urandom_range(0, 1) - $urandom_range(0, 1);
          default: t = (wp_count > 1) ? wp_time[0] + $urandom_range(0,
                         wp_time[wp_count-1] - wp_time[0]) : $urandom();
        endcase
        send(mk_req(CMD_QUERY, t, $urandom(), $urandom(), $urandom()));
      end
    end

    // Wait for outstanding results, then let the block settle
    in_valid <= 1'b0;
    drain_cnt = 0;
    while (pending_results.size() != 0 && drain_cnt < 2_000_000) begin
      @(posedge clk);
      drain_cnt++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
